// ===== hw/rtl/iis_pkg.sv =====
// Package for the instruction issue select unit: entry type, codes, defaults.
// Used by iis_cell and instruction_issue_select_unit. No dependencies.
`default_nettype none
package iis_pkg;
  localparam int unsigned DefWindowDepth = 32;
  localparam int unsigned DefMaxIssue    = 8;

  typedef enum logic [1:0] {OP_WAKEUP = 2'd0, OP_SELECT = 2'd1, OP_SQUASH = 2'd2,
                            OP_NONE = 2'd3} op_t;
  typedef enum logic [2:0] {ST_ISSUED = 3'd0, ST_NONE = 3'd1, ST_WAKE_OK = 3'd2,
                            ST_WAKE_FULL = 3'd3, ST_SQUASH = 3'd4} status_t;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_STORE = 2'd2;
  localparam logic [1:0] CFG_ORDER = 2'd0;
  localparam logic [1:0] CFG_EXEC  = 2'd1;
  localparam logic [1:0] CFG_MEM   = 2'd2;
  localparam logic [1:0] CFG_STORE = 2'd3;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] seq;
    logic [1:0]  kind;
    logic [7:0]  lat;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/iis_cell.sv =====
// One window cell: holds one entry and shifts toward the head of a rotating ring.
// Depends on iis_pkg.
`default_nettype none
module iis_cell (
  input  wire              clk,
  input  wire              load_en,
  input  iis_pkg::entry_t  load_data,
  input  wire              shift_en,
  input  iis_pkg::entry_t  prev_data,
  output iis_pkg::entry_t  data
);
  import iis_pkg::*;
  entry_t data_r;
  // A shift passes the neighbor's entry in; an append writes the new one.
  always_ff @(posedge clk) begin
    if (load_en) begin
      data_r <= load_data;
    end else if (shift_en) begin
      data_r <= prev_data;
    end
  end
  assign data = data_r;
endmodule
`default_nettype wire

// ===== hw/rtl/instruction_issue_select_unit.sv =====
// Instruction issue select unit: a chain of entry cells walked oldest first.
// Depends on iis_pkg and iis_cell.
//
//   channel | handshake             | payload
//   in      | start, busy           | in_op, in_tag, in_seq, in_kind, in_exec_latency,
//           |                       | in_cache_ready, in_squash_pos
//   out     | out_strobe (1 cycle)  | out_status, out_issued_tag, out_issued_latency, out_last
//   cfg     | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// Wakeup, squash and the unused op pass through the accepting cycle and a
// result cycle that presents the single result while busy is high.
// A select passes through the accepting cycle, a walk step for each window
// entry, a closing walk step and the final result cycle. Each walk
// cycle examines cell 0 and shifts the chain by one place; a kept entry is
// written back at the young end of the live window, so order is preserved.
// An issued result is held until the next instruction issues or the walk ends,
// so "last" is known when it leaves; the final one leaves in the result cycle.
// Reset clears the state, count, head pointer, pending flag and configuration registers; entries are not cleared.
// The receiver cannot stall; busy stays high until the final result is sent.
`default_nettype none
module instruction_issue_select_unit #(
  parameter int unsigned WINDOW_DEPTH = iis_pkg::DefWindowDepth,
  parameter int unsigned MAX_ISSUE    = iis_pkg::DefMaxIssue
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire  [1:0] in_op,
  input  wire  [7:0] in_tag,
  input  wire  [15:0] in_seq,
  input  wire  [1:0] in_kind,
  input  wire  [7:0] in_exec_latency,
  input  wire        in_cache_ready,
  input  wire  [15:0] in_squash_pos,
  output logic       out_strobe,
  output logic [2:0] out_status,
  output logic [7:0] out_issued_tag,
  output logic [7:0] out_issued_latency,
  output logic       out_last,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_index,
  input  wire  [3:0] cfg_data
);
  import iis_pkg::*;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned IW = $clog2(MAX_ISSUE + 1);
  localparam int unsigned EW = (IW > 4) ? IW : 4;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, left_r, left_nxt, keep_r, keep_nxt;
  logic [CW-1:0] tail;
  logic [15:0] head_r, head_nxt;
  logic order_r;
  logic [3:0] exec_r, memw_r, storew_r;
  logic [EW-1:0] cap_r, issued_r, issued_nxt, mem_r, mem_nxt, st_r, st_nxt;
  logic stop_r, stop_nxt, cache_r;
  logic [2:0] res_st_r, res_st_nxt;
  entry_t cells [WINDOW_DEPTH];
  entry_t in_entry, cur, ld_data;
  logic [WINDOW_DEPTH-1:0] load_en;
  logic shift_all;

  // Pending issued result, held so "last" is known when it leaves.
  logic pend_r, pend_nxt;
  logic [7:0] ptag_r, ptag_nxt, plat_r, plat_nxt;

  assign in_entry = '{tag: in_tag, seq: in_seq, kind: in_kind, lat: in_exec_latency};
  assign cur = cells[0];

  genvar g;
  generate
    for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      iis_cell u_cell (
        .clk(clk), .load_en(load_en[g]), .load_data(ld_data),
        .shift_en(shift_all), .prev_data(cells[(g + 1) % WINDOW_DEPTH]),
        .data(cells[g])
      );
    end
  endgenerate

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0; exec_r <= 4'd4; memw_r <= 4'd2; storew_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORDER: order_r  <= cfg_data[0];
        CFG_EXEC:  exec_r   <= cfg_data;
        CFG_MEM:   memw_r   <= cfg_data;
        CFG_STORE: storew_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; head_r <= '0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; head_r <= head_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt; keep_r <= keep_nxt; issued_r <= issued_nxt; mem_r <= mem_nxt;
    st_r <= st_nxt; stop_r <= stop_nxt; res_st_r <= res_st_nxt;
    ptag_r <= ptag_nxt; plat_r <= plat_nxt;
    if (state_r == S_IDLE) begin
      cache_r <= in_cache_ready;
      if (exec_r == 4'd0) cap_r <= EW'(1);
      else if (32'(exec_r) > MAX_ISSUE) cap_r <= EW'(MAX_ISSUE);
      else cap_r <= EW'(exec_r);
    end
  end

  logic is_ld, is_stq, blocked, can_issue;
  always_comb begin
    state_nxt = state_r; count_nxt = count_r; head_nxt = head_r;
    left_nxt = left_r; keep_nxt = keep_r; issued_nxt = issued_r; mem_nxt = mem_r;
    st_nxt = st_r; stop_nxt = stop_r; res_st_nxt = res_st_r;
    pend_nxt = pend_r; ptag_nxt = ptag_r; plat_nxt = plat_r;
    load_en = '0; shift_all = 1'b0; ld_data = in_entry;
    tail = left_r + keep_r - CW'(1);
    out_strobe = 1'b0; out_status = ST_NONE; out_issued_tag = '0;
    out_issued_latency = '0; out_last = 1'b0;
    is_ld = (cur.kind == KIND_LOAD);
    is_stq = (cur.kind == KIND_STORE);
    blocked = (is_ld && ({4'd0, mem_r} >= {{EW{1'b0}}, memw_r})) ||
              (is_stq && ({4'd0, st_r} >= {{EW{1'b0}}, storew_r})) ||
              ((is_ld || is_stq) && !cache_r);
    can_issue = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DONE;
          case (op_t'(in_op))
            OP_WAKEUP: begin
              if (32'(count_r) >= WINDOW_DEPTH) res_st_nxt = ST_WAKE_FULL;
              else begin
                res_st_nxt = ST_WAKE_OK;
                load_en[count_r[$clog2(WINDOW_DEPTH)-1:0]] = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_SQUASH: begin
              res_st_nxt = ST_SQUASH;
              if (in_squash_pos < head_r) head_nxt = in_squash_pos;
            end
            OP_SELECT: begin
              state_nxt = S_WALK; left_nxt = count_r; keep_nxt = '0;
              issued_nxt = '0; mem_nxt = '0; st_nxt = '0; stop_nxt = 1'b0;
            end
            default: res_st_nxt = ST_NONE;
          endcase
        end
      end
      S_WALK: begin
        if (left_r != '0) begin
          // The chain moves one place toward cell 0 each cycle.
          shift_all = 1'b1;
          left_nxt = left_r - CW'(1);
          if (!stop_r && issued_r < cap_r) begin
            if (order_r && cur.seq != head_r) stop_nxt = 1'b1;
            else if (blocked) begin
              if (order_r) stop_nxt = 1'b1;
            end else can_issue = 1'b1;
          end
          if (can_issue) begin
            // A newer issue means the held result is not the last one.
            if (pend_r) begin
              out_strobe = 1'b1; out_status = ST_ISSUED; out_issued_tag = ptag_r;
              out_issued_latency = plat_r;
            end
            pend_nxt = 1'b1; ptag_nxt = cur.tag; plat_nxt = cur.lat;
            issued_nxt = issued_r + EW'(1);
            if (is_ld || is_stq) mem_nxt = mem_r + EW'(1);
            if (is_stq) st_nxt = st_r + EW'(1);
            if (order_r) head_nxt = head_r + 16'd1;
          end else begin
            // Kept entries go back in at the young end of the live window.
            load_en[tail[$clog2(WINDOW_DEPTH)-1:0]] = 1'b1;
            ld_data = cur;
            keep_nxt = keep_r + CW'(1);
          end
        end else begin
          count_nxt = keep_r;
          state_nxt = S_DONE;
          res_st_nxt = (issued_r == '0) ? ST_NONE : ST_ISSUED;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
        out_strobe = 1'b1; out_last = 1'b1;
        if (pend_r) begin
          out_status = ST_ISSUED; out_issued_tag = ptag_r; out_issued_latency = plat_r;
          pend_nxt = 1'b0;
        end else out_status = res_st_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== dv/instruction_issue_select_unit_tb.sv =====
// Testbench for the instruction issue select unit: directed and random wakeup,
// select and squash traffic checked against an in-bench predictor.
// Depends on iis_pkg and the instruction_issue_select_unit RTL.
`default_nettype none

module instruction_issue_select_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iis_pkg::*;

  localparam int unsigned Depth = DefWindowDepth;
  localparam int unsigned MaxIssue = DefMaxIssue;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] tag;
    logic [7:0] lat;
    logic       last;
  } issue_result_t;

  // Scoreboard: predicts the window behavior and holds the expected results.
  class issue_scoreboard;
    entry_t window[$];
    logic [15:0] head;
    logic order_mode;
    logic [3:0] exec_w, mem_w, store_w;
    issue_result_t pending[$];
    int errors;

    function new();
      head = '0; order_mode = 1'b0; exec_w = 4'd4; mem_w = 4'd2; store_w = 4'd1;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] data);
      case (idx)
        CFG_ORDER: order_mode = data[0];
        CFG_EXEC:  exec_w = data;
        CFG_MEM:   mem_w = data;
        default:   store_w = data;
      endcase
    endfunction

    function void push_result(status_t st, logic [7:0] tag, logic [7:0] lat, logic last);
      issue_result_t r;
      r.status = st; r.tag = tag; r.lat = lat; r.last = last;
      pending.push_back(r);
    endfunction

    // Notes an accepted input transfer and predicts the results it causes.
    function void note_input(op_t op, logic [7:0] tag, logic [15:0] seq, logic [1:0] kind,
                             logic [7:0] lat, logic cache_ok, logic [15:0] pos);
      entry_t e, kept[$];
      int cap, issued, mem, stores;
      bit stop, is_ld, is_st, blocked;
      case (op)
        OP_WAKEUP: begin
          if (window.size() >= Depth) begin
            push_result(ST_WAKE_FULL, 8'd0, 8'd0, 1'b1);
          end else begin
            e.tag = tag; e.seq = seq; e.kind = kind; e.lat = lat;
            window.push_back(e);
            push_result(ST_WAKE_OK, 8'd0, 8'd0, 1'b1);
          end
        end
        OP_SQUASH: begin
          if (pos < head) head = pos;
          push_result(ST_SQUASH, 8'd0, 8'd0, 1'b1);
        end
        OP_SELECT: begin
          cap = (exec_w == 0) ? 1 : (exec_w > MaxIssue ? MaxIssue : exec_w);
          issued = 0; mem = 0; stores = 0; stop = 0;
          foreach (window[i]) begin
            e = window[i];
            is_ld = (e.kind == KIND_LOAD);
            is_st = (e.kind == KIND_STORE);
            if (stop || issued >= cap) begin
              kept.push_back(e);
              continue;
            end
            if (order_mode && e.seq != head) begin
              stop = 1; kept.push_back(e);
              continue;
            end
            blocked = (is_ld && mem >= mem_w) || (is_st && stores >= store_w) ||
                      ((is_ld || is_st) && !cache_ok);
            if (blocked) begin
              if (order_mode) stop = 1;
              kept.push_back(e);
              continue;
            end
            if (order_mode) head = head + 16'd1;
            push_result(ST_ISSUED, e.tag, e.lat, 1'b0);
            issued++;
            if (is_ld || is_st) mem++;
            if (is_st) stores++;
          end
          window = kept;
          if (issued == 0) push_result(ST_NONE, 8'd0, 8'd0, 1'b1);
          else pending[pending.size()-1].last = 1'b1;
        end
        default: push_result(ST_NONE, 8'd0, 8'd0, 1'b1);
      endcase
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(issue_result_t got);
      issue_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d tag=%0d lat=%0d last=%0d",
                 $realtime, got.status, got.tag, got.lat, got.last);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status != exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, got.status);
        errors++;
      end
      if (got.tag != exp_r.tag) begin
        $display("%0t: issued_tag expected %0d actual %0d", $realtime, exp_r.tag, got.tag);
        errors++;
      end
      if (got.lat != exp_r.lat) begin
        $display("%0t: issued_latency expected %0d actual %0d", $realtime, exp_r.lat, got.lat);
        errors++;
      end
      if (got.last != exp_r.last) begin
        $display("%0t: last expected %0d actual %0d", $realtime, exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [1:0] in_op, in_kind;
  logic [7:0] in_tag, in_exec_latency;
  logic [15:0] in_seq, in_squash_pos;
  logic in_cache_ready;
  logic out_strobe, out_last;
  logic [2:0] out_status;
  logic [7:0] out_issued_tag, out_issued_latency;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  issue_scoreboard board;
  logic [15:0] seq_next;  // Program-order counter for well-formed in-order traffic.

  instruction_issue_select_unit u_dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_tag, .in_seq, .in_kind, .in_exec_latency,
    .in_cache_ready, .in_squash_pos, .out_strobe, .out_status, .out_issued_tag,
    .out_issued_latency, .out_last, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every result strobe is a transfer; the receiver never stalls.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      board.check_result({out_status, out_issued_tag, out_issued_latency, out_last});
    end
  end

  // Sends one item after a random gap, possibly none; waits for the transfer.
  // Start drops during a gap; with no gap the next item follows directly.
  task automatic send_item(op_t op, logic [7:0] tag, logic [15:0] seq, logic [1:0] kind,
                           logic [7:0] lat, logic cache_ok, logic [15:0] pos);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_op <= op; in_tag <= tag; in_seq <= seq; in_kind <= kind;
    in_exec_latency <= lat; in_cache_ready <= cache_ok; in_squash_pos <= pos;
    do @(posedge clk); while (busy);
    board.note_input(op, tag, seq, kind, lat, cache_ok, pos);
    @(negedge clk);
  endtask

  // Wakes an instruction with random content; mostly the next program-order seq.
  task automatic wake_random();
    logic [15:0] s;
    s = ($urandom_range(0, 9) < 8) ? seq_next : 16'($urandom);
    if (s == seq_next) seq_next = seq_next + 16'd1;
    send_item(OP_WAKEUP, 8'($urandom), s, 2'($urandom), 8'($urandom), 1'b0, 16'($urandom));
  endtask

  // Drops start, waits until the block has drained, then a little longer.
  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (board.pending.size() != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    repeat (2 * Depth + 8) @(negedge clk);
  endtask

  // Writes one register through the configuration channel while idle.
  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(logic order, logic [3:0] ex, logic [3:0] mm, logic [3:0] st);
    drain();
    write_reg(CFG_ORDER, {3'b0, order});
    write_reg(CFG_EXEC, ex);
    write_reg(CFG_MEM, mm);
    write_reg(CFG_STORE, st);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int k, r;
    board = new();
    seq_next = '0;
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_op = '0; in_tag = '0; in_seq = '0; in_kind = '0; in_exec_latency = '0;
    in_cache_ready = 1'b0; in_squash_pos = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, every kind including the unknown one, blocked
    // memory operations, an empty select and the unused op code.
    send_item(OP_SELECT, 8'd0, 16'd0, 2'd0, 8'd0, 1'b1, 16'd0);
    send_item(OP_WAKEUP, 8'hFF, 16'd0, 2'd1, 8'hFF, 1'b1, 16'hFFFF);
    send_item(OP_WAKEUP, 8'h00, 16'd1, 2'd2, 8'h00, 1'b0, 16'h0000);
    send_item(OP_WAKEUP, 8'h5A, 16'd2, 2'd3, 8'hA5, 1'b1, 16'd0);
    send_item(OP_WAKEUP, 8'h11, 16'hFFFF, 2'd0, 8'h22, 1'b0, 16'd0);
    send_item(OP_SELECT, 8'hFF, 16'hFFFF, 2'd3, 8'hFF, 1'b0, 16'hFFFF);
    send_item(OP_SELECT, 8'd0, 16'd0, 2'd0, 8'd0, 1'b1, 16'd0);
    send_item(OP_NONE, 8'hFF, 16'hFFFF, 2'd3, 8'hFF, 1'b1, 16'hFFFF);
    send_item(OP_SQUASH, 8'd0, 16'd0, 2'd0, 8'd0, 1'b0, 16'hFFFF);
    // Fill the window past full so the refusal shows up.
    for (k = 0; k < Depth + 2; k++) begin
      send_item(OP_WAKEUP, 8'(k), 16'(k), 2'd0, 8'(k), 1'b0, 16'd0);
    end
    send_item(OP_SELECT, 8'd0, 16'd0, 2'd0, 8'd0, 1'b1, 16'd0);

    // In-order mode selects, then a squash to position zero and more selects.
    configure(1'b1, 4'd15, 4'd8, 4'd8);
    for (k = 0; k < 4; k++) send_item(OP_SELECT, 8'd0, 16'd0, 2'd0, 8'd0, 1'b1, 16'd0);
    send_item(OP_SQUASH, 8'd0, 16'd0, 2'd0, 8'd0, 1'b0, 16'd0);
    for (k = 0; k < 4; k++) send_item(OP_SELECT, 8'd0, 16'd0, 2'd0, 8'd0, 1'b1, 16'd0);

    // Random phases over several settings, extremes among them.
    for (r = 0; r < 8; r++) begin
      case (r)
        0: configure(1'b0, 4'd0, 4'd0, 4'd0);
        1: configure(1'b0, 4'd8, 4'd8, 4'd8);
        2: configure(1'b1, 4'd4, 4'd2, 4'd1);
        3: configure(1'b0, 4'd1, 4'd15, 4'd15);
        default: configure($urandom_range(0, 1), 4'($urandom), 4'($urandom), 4'($urandom));
      endcase
      send_item(OP_SQUASH, 8'd0, 16'd0, 2'd0, 8'd0, 1'b0, 16'd0);
      seq_next = '0;
      for (k = 0; k < 34; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: wake_random();
          5, 6, 7: send_item(OP_SELECT, 8'($urandom), 16'($urandom), 2'($urandom),
                             8'($urandom), $urandom_range(0, 3) != 0, 16'($urandom));
          8: send_item(OP_SQUASH, 8'($urandom), 16'($urandom), 2'($urandom),
                       8'($urandom), 1'($urandom),
                       ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40))));
          default: send_item(OP_NONE, 8'($urandom), 16'($urandom), 2'($urandom),
                             8'($urandom), 1'($urandom), 16'($urandom));
        endcase
      end
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (board.pending.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $realtime, board.pending.size());
      end
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule

`default_nettype wire
